// ----- hw/rtl/opp_pkg.sv -----
package opp_pkg;

  // Sample and result widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned EncW    = 25;
  localparam int unsigned ScaleW  = 12;
  localparam int unsigned RatioW  = 9;
  localparam int unsigned FracW   = 10;
  localparam int unsigned NextW   = 28;
  localparam int unsigned ProdW   = NextW + RatioW;
  localparam int unsigned SumW    = 28;

  // Configuration register indexes and reset values
  localparam logic [7:0] RegTopScale  = 8'd0;
  localparam logic [7:0] RegStepRatio = 8'd1;
  localparam logic [ScaleW-1:0] TopScaleReset  = 12'd1365;
  localparam logic [RatioW-1:0] StepRatioReset = 9'd128;

  // Largest encoded value
  localparam logic [SumW-1:0] EncMax = 28'd33553920;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // insert the incoming sample
    logic prep;   // multiply column max by the top scale
    logic top;    // settle the sentinel
    logic rd;     // read the arrival store
    logic cmp;    // compare against the sorted cells
    logic sel;    // pick the next larger value, form the gap
    logic mul;    // scale the gap
    logic fin;    // load the output register
    logic adv;    // move to the next arrival entry
    logic clear;  // empty the column
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_item;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/opp_ram.sv -----
module opp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/opp_ctrl.sv -----
module opp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             last,
  output logic             in_stall,
  input  opp_pkg::status_t status,
  output opp_pkg::cmd_t    cmd
);

  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StPrep = 3'd1;
  localparam logic [2:0] StTop  = 3'd2;
  localparam logic [2:0] StRd   = 3'd3;
  localparam logic [2:0] StCmp  = 3'd4;
  localparam logic [2:0] StSel  = 3'd5;
  localparam logic [2:0] StMul  = 3'd6;
  localparam logic [2:0] StFin  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != StLoad);

  // Sequence the load and emit phases
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      StLoad: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last) begin
            state_next = StPrep;
          end
        end
      end
      StPrep: begin
        cmd.prep = 1'b1;
        state_next = StTop;
      end
      StTop: begin
        cmd.top = 1'b1;
        state_next = StRd;
      end
      StRd: begin
        cmd.rd = 1'b1;
        state_next = StCmp;
      end
      StCmp: begin
        cmd.cmp = 1'b1;
        state_next = StSel;
      end
      StSel: begin
        cmd.sel = 1'b1;
        state_next = StMul;
      end
      StMul: begin
        cmd.mul = 1'b1;
        state_next = StFin;
      end
      StFin: begin
        if (status.out_free) begin
          cmd.fin = 1'b1;
          if (status.last_item) begin
            cmd.clear = 1'b1;
            state_next = StLoad;
          end else begin
            cmd.adv = 1'b1;
            state_next = StRd;
          end
        end
      end
      default: state_next = StLoad;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StLoad;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/opp_datapath.sv -----
module opp_datapath #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  opp_pkg::cmd_t                  cmd,
  output opp_pkg::status_t               status,
  input  logic [opp_pkg::SampleW-1:0]    sample,
  input  logic                           cfg_valid,
  input  logic [7:0]                     cfg_index,
  input  logic [15:0]                    cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [opp_pkg::EncW-1:0]       encoded,
  output logic                           final_res
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW = opp_pkg::SampleW;
  localparam int unsigned FW = opp_pkg::FracW;
  localparam int unsigned NW = opp_pkg::NextW;

  logic [opp_pkg::ScaleW-1:0] top_scale;
  logic [opp_pkg::RatioW-1:0] step_ratio;

  logic [CW-1:0]  count;
  logic           full;
  logic [SW-1:0]  col_max;
  logic [SW-1:0]  cells [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] valid;
  logic [MAX_ITEMS-1:0] gt;
  logic [MAX_ITEMS-1:0] gt_r;
  logic [MAX_ITEMS-1:0] sel_oh;
  logic [SW-1:0]  cmp_val;
  logic [SW-1:0]  rd_data;
  logic [SW-1:0]  cur_s;
  logic [SW-1:0]  nxt_val;
  logic [AW-1:0]  idx;
  logic           ins;

  logic [NW-1:0]  top_prod;
  logic [NW-1:0]  top_next;
  logic [NW-1:0]  next_v;
  logic [NW-1:0]  gap;
  logic [opp_pkg::ProdW-1:0] gap_prod;
  logic [opp_pkg::SumW-1:0]  enc_sum;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      top_scale  <= opp_pkg::TopScaleReset;
      step_ratio <= opp_pkg::StepRatioReset;
    end else if (cfg_valid) begin
      if (cfg_index == opp_pkg::RegTopScale) begin
        top_scale <= cfg_data[opp_pkg::ScaleW-1:0];
      end else if (cfg_index == opp_pkg::RegStepRatio) begin
        step_ratio <= cfg_data[opp_pkg::RatioW-1:0];
      end
    end
  end

  assign full = (count == CW'(MAX_ITEMS));
  assign ins  = cmd.load && !full;

  // Arrival-order store
  opp_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_ITEMS)
  ) u_arrival (
    .clk   (clk),
    .we    (ins),
    .waddr (count[AW-1:0]),
    .wdata (sample),
    .re    (cmd.rd),
    .raddr (idx),
    .rdata (rd_data)
  );

  // Shared compare row: new sample while loading, stored sample while emitting
  assign cmp_val = cmd.cmp ? rd_data : sample;

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    assign gt[k] = valid[k] && (cells[k] > cmp_val);
    if (k == 0) begin : g_first
      assign sel_oh[k] = gt_r[k];
      always_ff @(posedge clk) begin
        if (ins && (gt[k] || count == CW'(k))) begin
          cells[k] <= sample;
        end
      end
    end else begin : g_rest
      assign sel_oh[k] = gt_r[k] && !gt_r[k-1];
      // Shift larger values up one place, drop the sample into its slot
      always_ff @(posedge clk) begin
        if (ins) begin
          if (gt[k-1]) begin
            cells[k] <= cells[k-1];
          end else if (gt[k] || count == CW'(k)) begin
            cells[k] <= sample;
          end
        end
      end
    end
  end

  // Column bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      valid   <= '0;
      col_max <= '0;
      idx     <= '0;
    end else if (cmd.clear) begin
      count   <= '0;
      valid   <= '0;
      col_max <= '0;
      idx     <= '0;
    end else begin
      if (ins) begin
        valid[count[AW-1:0]] <= 1'b1;
        count <= count + CW'(1);
        if (sample > col_max) begin
          col_max <= sample;
        end
      end
      if (cmd.adv) begin
        idx <= idx + AW'(1);
      end
    end
  end

  assign status.last_item = ({1'b0, idx} == (count - CW'(1)));

  // Pick the first cell above the current sample
  always_comb begin
    nxt_val = '0;
    for (int k = 0; k < MAX_ITEMS; k++) begin
      nxt_val = nxt_val | ({SW{sel_oh[k]}} & cells[k]);
    end
  end

  // Next larger value, or the sentinel when none is above
  assign next_v = (|gt_r) ? NW'({nxt_val, {FW{1'b0}}}) : top_next;

  // Sentinel, compare, gap and scaling stages
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      top_prod <= NW'(col_max) * NW'(top_scale);
    end
    if (cmd.top) begin
      if (top_prod > NW'({col_max, {FW{1'b0}}})) begin
        top_next <= top_prod;
      end else begin
        top_next <= NW'({(SW + 1)'(col_max) + (SW + 1)'(1), {FW{1'b0}}});
      end
    end
    if (cmd.cmp) begin
      cur_s <= rd_data;
      gt_r  <= gt;
    end
    if (cmd.sel) begin
      gap <= next_v - NW'({cur_s, {FW{1'b0}}});
    end
    if (cmd.mul) begin
      gap_prod <= gap * step_ratio;
    end
  end

  assign enc_sum = opp_pkg::SumW'({cur_s, 8'd0})
                 + opp_pkg::SumW'(gap_prod[opp_pkg::ProdW-1:FW]);

  assign status.out_free = !out_valid || !out_stall;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      encoded   <= (enc_sum > opp_pkg::EncMax) ? opp_pkg::EncMax[opp_pkg::EncW-1:0]
                                               : enc_sum[opp_pkg::EncW-1:0];
      final_res <= status.last_item;
    end
  end

  // Fill level never passes the column depth
  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_ITEMS))
    else $error("column count overflow");

  // Valid cells form a prefix of the chain
  assert property (@(posedge clk) disable iff (rst)
    valid == MAX_ITEMS'((({(MAX_ITEMS + 1){1'b0}} | 1'b1) << count) - 1'b1))
    else $error("cell valid bits out of step with count");

  // Compare mask after the one-hot pick holds at most one cell
  assert property (@(posedge clk) disable iff (rst) cmd.sel |-> $onehot0(sel_oh))
    else $error("next-larger pick not one-hot");

  // A result is loaded only into a free output register
  assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting result");

endmodule

// ----- hw/rtl/order_preserving_perturb_unit.sv -----
// Order-preserving perturbation of one feature column.
//
// Input channel (in_valid / in_stall, sample, last): one unsigned sample per
// transaction. Samples are stored in arrival order and inserted into a sorted
// cell chain in the cycle they are taken, so loading runs at one sample per
// cycle. Samples beyond MAX_ITEMS are dropped; last still starts the emit.
// After the transaction marked last, in_stall stays high while the column is
// emitted: the prep and top steps form the sentinel, then each result passes
// through arrival store read, compare row, next-larger pick, gap multiply and
// output load.
// Output channel (out_valid / out_stall, encoded, final_res): results come in
// arrival order, final_res on the last one. A stalled result holds in the
// output register and the emit sequencer waits for it.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): always ready;
// index 0 is top_scale, index 1 is step_ratio, others are ignored.
// Reset (rst, synchronous) empties the column and restores both registers.
module order_preserving_perturb_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] sample,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [24:0] encoded,
  output logic        final_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  opp_pkg::cmd_t    cmd;
  opp_pkg::status_t status;

  assign cfg_ready = 1'b1;

  opp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  opp_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (sample),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .encoded   (encoded),
    .final_res (final_res)
  );

endmodule

// ----- bench/order_preserving_perturb_unit_tb.sv -----
`timescale 1ns / 1ps
module order_preserving_perturb_unit_tb;

  localparam int unsigned ColMax = 64;
  localparam int unsigned RandItems = 250;
  localparam int unsigned IdleLimit = 20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [15:0] sample;
  logic last;
  logic out_valid;
  logic out_stall;
  logic [24:0] encoded;
  logic final_res;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_index;
  logic [15:0] cfg_data;

  order_preserving_perturb_unit #(.MAX_ITEMS(ColMax)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .encoded(encoded),
    .final_res(final_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [24:0] enc;
    logic fin;
  } perturbed_t;

  // Directed row: sample, last mark, and an optional typed-in expectation
  typedef struct {
    logic [15:0] smp;
    logic lst;
    logic has_exp;
    logic [24:0] exp_enc;
  } dir_row_t;

  // Predictor state
  logic [opp_pkg::ScaleW-1:0] pred_scale;
  logic [opp_pkg::RatioW-1:0] pred_ratio;
  logic [15:0] col_arrival[ColMax];
  logic [15:0] col_sorted[ColMax];
  int unsigned col_count;

  perturbed_t pending_q[$];
  logic [24:0] typed_q[$];
  logic [24:0] typed_next;
  int unsigned fail_count;
  int unsigned idle_cycles;
  logic calm;
  logic hold_long;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Perturbed value of one stored sample, with the current settings
  function automatic logic [24:0] perturb_value(input logic [15:0] s);
    logic [63:0] nxt;
    logic [63:0] mx;
    logic [63:0] base;
    logic [63:0] gap;
    logic [63:0] enc;
    logic found;
    found = 1'b0;
    nxt = '0;
    for (int k = 0; k < col_count; k++) begin
      if (!found && col_sorted[k] > s) begin
        nxt = 64'(col_sorted[k]) * 1024;
        found = 1'b1;
      end
    end
    if (!found) begin
      mx = (col_count > 0) ? 64'(col_sorted[col_count-1]) : 64'd0;
      nxt = mx * 64'(pred_scale);
      if (nxt <= mx * 1024) nxt = (mx + 1) * 1024;
    end
    base = 64'(s) * 1024;
    gap = (nxt > base) ? nxt - base : 64'd0;
    enc = 64'(s) * 256 + ((gap * 64'(pred_ratio)) >> 10);
    if (enc > 64'(opp_pkg::EncMax)) enc = 64'(opp_pkg::EncMax);
    return enc[24:0];
  endfunction

  // Take one accepted sample into the predictor; queue results on last
  task automatic column_accept(input logic [15:0] s, input logic lst);
    int unsigned pos;
    perturbed_t r;
    if (col_count < ColMax) begin
      col_arrival[col_count] = s;
      pos = col_count;
      while (pos > 0 && col_sorted[pos-1] > s) begin
        col_sorted[pos] = col_sorted[pos-1];
        pos--;
      end
      col_sorted[pos] = s;
      col_count++;
    end
    if (lst) begin
      for (int i = 0; i < col_count; i++) begin
        r.enc = perturb_value(col_arrival[i]);
        r.fin = (i + 1 == col_count);
        pending_q.insert(pending_q.size(), r);
      end
      col_count = 0;
    end
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    perturbed_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result encoded=%0d final_res=%0b", encoded, final_res);
        fail_count++;
      end else begin
        e = pending_q.pop_front();
        if (encoded !== e.enc) begin
          $error("encoded: expected %0d, actual %0d", e.enc, encoded);
          fail_count++;
        end
        if (final_res !== e.fin) begin
          $error("final_res: expected %0b, actual %0b", e.fin, final_res);
          fail_count++;
        end
        if (typed_q.size() > 0) begin
          typed_next = typed_q.pop_front();
          if (typed_next !== 25'h1FFFFFF && encoded !== typed_next) begin
            $error("encoded: expected %0d, actual %0d", typed_next, encoded);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall = 1'b1;
        for (int i = 0; i < 400; i++) @(negedge clk);
        out_stall = 1'b0;
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
        out_stall = 1'b1;
        for (int i = 1; i < n; i++) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Drive one sample and wait for its transaction
  task automatic send_sample(input logic [15:0] s, input logic lst);
    int unsigned n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      n = $urandom_range(1, 10);
      repeat (n) @(negedge clk);
    end
    in_valid = 1'b1;
    sample = s;
    last = lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    column_accept(s, lst);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait until all results are in, plus the tail of the emit
  task automatic drain;
    while (pending_q.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == opp_pkg::RegTopScale) pred_scale = val[opp_pkg::ScaleW-1:0];
    else if (idx == opp_pkg::RegStepRatio) pred_ratio = val[opp_pkg::RatioW-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random column: mostly short, a few near, at or beyond full depth
  task automatic random_column(output int unsigned used);
    int unsigned len;
    int unsigned mode;
    logic [15:0] s;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
    mode = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: s = 16'($urandom_range(0, 7));
        1: s = 16'hFFFF - 16'($urandom_range(0, 3));
        default: s = 16'($urandom);
      endcase
      send_sample(s, i == len - 1);
    end
    used = len;
  endtask

  dir_row_t dir_rows[] = '{
    '{16'd0, 1'b1, 1'b1, 25'd128},          // all-zero column: max plus one
    '{16'hFFFF, 1'b1, 1'b0, 25'd0},
    '{16'd10, 1'b0, 1'b0, 25'd0},
    '{16'd20, 1'b0, 1'b0, 25'd0},
    '{16'd10, 1'b0, 1'b0, 25'd0},           // equal samples share a neighbor
    '{16'd5, 1'b1, 1'b0, 25'd0},
    '{16'd0, 1'b0, 1'b0, 25'd0},
    '{16'hFFFF, 1'b1, 1'b0, 25'd0},
    '{16'h5555, 1'b0, 1'b0, 25'd0},
    '{16'hAAAA, 1'b1, 1'b0, 25'd0}
  };

  initial begin
    int unsigned sent;
    int unsigned used;
    rst = 1'b1;
    in_valid = 1'b0;
    sample = '0;
    last = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_long = 1'b0;
    fail_count = 0;
    col_count = 0;
    pred_scale = opp_pkg::TopScaleReset;
    pred_ratio = opp_pkg::StepRatioReset;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed rows at reset settings; one result per row, in arrival order
    foreach (dir_rows[i]) begin
      typed_q.insert(typed_q.size(),
                     dir_rows[i].has_exp ? dir_rows[i].exp_enc : 25'h1FFFFFF);
      send_sample(dir_rows[i].smp, dir_rows[i].lst);
    end
    drain();
    typed_q.delete();

    // Overfull column: drop past the limit, last on a dropped sample
    for (int i = 0; i < ColMax + 3; i++) send_sample(16'($urandom), i == ColMax + 2);
    drain();

    // Extremes of the settings, including out-of-range and masked values
    write_reg(opp_pkg::RegTopScale, 16'd1024);
    write_reg(opp_pkg::RegStepRatio, 16'd256);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'd3, 1'b0);
    send_sample(16'd3, 1'b1);
    drain();
    write_reg(opp_pkg::RegTopScale, 16'hFFFF);
    write_reg(opp_pkg::RegStepRatio, 16'hFFFF);
    write_reg(8'd7, 16'h1234);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd0, 1'b1);
    drain();

    // Long receiver hold-off while samples keep coming
    write_reg(opp_pkg::RegTopScale, 16'd2048);
    write_reg(opp_pkg::RegStepRatio, 16'd0);
    hold_long = 1'b1;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 5; i++) send_sample(16'($urandom), i == 4);
    end
    drain();

    // Random columns across several settings, last part without idling
    sent = 0;
    while (sent < RandItems) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_reg(opp_pkg::RegTopScale, 16'($urandom_range(1024, 2048)));
        write_reg(opp_pkg::RegStepRatio, 16'($urandom_range(0, 256)));
      end
      if (sent > RandItems * 3 / 4) calm = 1'b1;
      random_column(used);
      sent += used;
    end
    drain();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/opp_pkg.sv
hw/rtl/opp_ram.sv
hw/rtl/opp_ctrl.sv
hw/rtl/opp_datapath.sv
hw/rtl/order_preserving_perturb_unit.sv
bench/order_preserving_perturb_unit_tb.sv
